FILE: rtl/core/cesc_pkg.sv
`default_nettype none

package cesc_pkg;

  localparam int SID_COUNT = 16;
  localparam int SID_W = (SID_COUNT > 1) ? $clog2(SID_COUNT) : 1;
  localparam int NCNT = 11;
  localparam int CNT_W = 32;
  localparam int PLEN_W = 17;
  localparam int MEAS_W = 31;
  localparam int FLAG_W = 10;
  localparam int IN_TDATA_W = 144;
  localparam int OUT_TDATA_W = 168;

  typedef enum logic [1:0] {
    MODE_EVENT  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_DROPPED = 2'd1,
    ST_READ    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  localparam logic [1:0] CFG_FORMAT  = 2'd0;
  localparam logic [1:0] CFG_INVALID = 2'd1;
  localparam logic [1:0] CFG_NODATA  = 2'd2;

  localparam logic [3:0] C_CYCLES    = 4'd0;
  localparam logic [3:0] C_TRIGGER   = 4'd1;
  localparam logic [3:0] C_START     = 4'd2;
  localparam logic [3:0] C_STOP      = 4'd3;
  localparam logic [3:0] C_NOBEAM    = 4'd4;
  localparam logic [3:0] C_BLOCK     = 4'd5;
  localparam logic [3:0] C_INTERLOCK = 4'd6;
  localparam logic [3:0] C_FAILCHOP  = 4'd7;
  localparam logic [3:0] C_WRONGTRIG = 4'd8;
  localparam logic [3:0] C_CCIREC    = 4'd9;
  localparam logic [3:0] C_CCILATE   = 4'd10;

  localparam logic [MEAS_W-1:0] MEAS_INVALID = 31'h7fffffff;

  typedef logic [NCNT-1:0][CNT_W-1:0] cnt_row_t;

  typedef struct packed {
    logic [3:0]  format_code;
    logic [15:0] invalid_code;
    logic [15:0] nodata_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] event_id;
    logic [63:0] param_word;
    logic        machine;
    logic [3:0]  entry_sid;
    logic [3:0]  counter_index;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic                machine;
    logic [11:0]         sid;
    logic [FLAG_W-1:0]   flag_bits;
    logic [MEAS_W-1:0]   trigger_length;
    logic [MEAS_W-1:0]   pulse_start_time;
    logic [MEAS_W-1:0]   pulse_stop_time;
    logic [PLEN_W-1:0]   pulse_length;
    logic [CNT_W-1:0]    counter_value;
  } result_t;

  typedef struct packed {
    cnt_row_t          cnt;
    logic [PLEN_W-1:0] plen;
  } store_rd_t;

  typedef struct packed {
    logic              wr;
    logic              clr;
    logic              machine;
    logic [SID_W-1:0]  idx;
    cnt_row_t          cnt;
    logic [PLEN_W-1:0] plen;
  } store_upd_t;

endpackage

`default_nettype wire

FILE: rtl/core/cesc_store.sv
`default_nettype none

module cesc_store (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   rd_machine,
  input  wire logic [cesc_pkg::SID_W-1:0] rd_idx,
  output cesc_pkg::store_rd_t         rd,
  input  wire cesc_pkg::store_upd_t   upd
);
  import cesc_pkg::*;

  logic [1:0][SID_COUNT-1:0] valid_r;
  cnt_row_t                  cnt_r  [2][SID_COUNT];
  logic [PLEN_W-1:0]         plen_r [2][SID_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (upd.wr) begin
        valid_r[upd.machine][upd.idx] <= 1'b1;
      end
      if (upd.clr) begin
        valid_r[0][upd.idx] <= 1'b0;
        valid_r[1][upd.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.wr) begin
      cnt_r[upd.machine][upd.idx]  <= upd.cnt;
      plen_r[upd.machine][upd.idx] <= upd.plen;
    end
  end

  // A row that was never written since reset or its last clear reads as zero.
  always_comb begin
    if (valid_r[rd_machine][rd_idx]) begin
      rd.cnt  = cnt_r[rd_machine][rd_idx];
      rd.plen = plen_r[rd_machine][rd_idx];
    end else begin
      rd = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cesc_calc.sv
`default_nettype none

module cesc_calc (
  input  wire cesc_pkg::item_t            item,
  input  wire cesc_pkg::cfg_t             cfg,
  input  wire logic                       go,
  output logic                            rd_machine,
  output logic [cesc_pkg::SID_W-1:0]      rd_idx,
  input  wire cesc_pkg::store_rd_t        rd,
  output cesc_pkg::result_t               res,
  output cesc_pkg::store_upd_t            upd
);
  import cesc_pkg::*;

  logic [3:0]        fid;
  logic [11:0]       sid;
  logic [13:0]       bpid;
  logic [5:0]        attr;
  logic              blk, ilk, crec, clate, nob;
  logic [15:0]       trg_raw, sta_raw, sto_raw;
  logic              trg, sta, sto, wt, fc;
  logic [MEAS_W-1:0] trg_val, sta_val, sto_val;
  logic              ev_ok, sid_ok, cidx_ok;
  logic [NCNT-1:0]   inc;
  cnt_row_t          new_cnt;
  logic [PLEN_W-1:0] new_plen;

  function automatic logic [MEAS_W-1:0] shown(input logic [15:0] raw, input cfg_t c);
    logic [MEAS_W-1:0] v;
    if (raw == c.invalid_code) v = MEAS_INVALID;
    else if (raw == c.nodata_code) v = '0;
    else v = MEAS_W'(raw);
    return v;
  endfunction

  assign fid   = item.event_id[63:60];
  assign sid   = item.event_id[31:20];
  assign bpid  = item.event_id[19:6];
  assign attr  = item.event_id[5:0];
  assign blk   = bpid[2];
  assign ilk   = bpid[3];
  assign crec  = bpid[4];
  assign clate = bpid[5];
  assign nob   = attr[2];

  assign trg_raw = item.param_word[63:48];
  assign sta_raw = item.param_word[47:32];
  assign sto_raw = item.param_word[31:16];

  assign trg = (trg_raw != cfg.invalid_code) && (trg_raw != cfg.nodata_code);
  assign sta = (sta_raw != cfg.invalid_code) && (sta_raw != cfg.nodata_code);
  assign sto = (sto_raw != cfg.invalid_code) && (sto_raw != cfg.nodata_code);
  assign trg_val = shown(trg_raw, cfg);
  assign sta_val = shown(sta_raw, cfg);
  assign sto_val = shown(sto_raw, cfg);

  assign wt = (nob | blk | ilk) & trg;
  assign fc = ~(nob | blk | ilk) & ~sto;

  assign ev_ok   = (fid == cfg.format_code) && ({1'b0, sid} < 13'(SID_COUNT));
  assign sid_ok  = {9'd0, item.entry_sid} < 13'(SID_COUNT);
  assign cidx_ok = item.counter_index < 4'(NCNT);

  assign rd_machine = item.machine;
  assign rd_idx = (item.mode == MODE_EVENT) ? SID_W'(sid) : SID_W'(item.entry_sid);

  always_comb begin
    inc              = '0;
    inc[C_CYCLES]    = 1'b1;
    inc[C_TRIGGER]   = trg;
    inc[C_START]     = sta;
    inc[C_STOP]      = sto;
    inc[C_NOBEAM]    = nob;
    inc[C_BLOCK]     = blk;
    inc[C_INTERLOCK] = ilk;
    inc[C_FAILCHOP]  = fc;
    inc[C_WRONGTRIG] = wt;
    inc[C_CCIREC]    = crec;
    inc[C_CCILATE]   = clate;
    for (int c = 0; c < NCNT; c++) begin
      new_cnt[c] = rd.cnt[c] + CNT_W'(inc[c]);
    end
  end

  assign new_plen = (sta && sto) ? ({1'b0, sto_raw} - {1'b0, sta_raw}) : rd.plen;

  always_comb begin
    res         = '0;
    res.status  = ST_DROPPED;
    upd         = '0;
    upd.machine = item.machine;
    upd.idx     = rd_idx;
    upd.cnt     = new_cnt;
    upd.plen    = new_plen;
    unique case (item.mode)
      MODE_EVENT: begin
        if (ev_ok) begin
          res.status           = ST_APPLIED;
          res.machine          = item.machine;
          res.sid              = sid;
          res.flag_bits        = {fc, wt, clate, crec, ilk, blk, nob, sto, sta, trg};
          res.trigger_length   = trg_val;
          res.pulse_start_time = sta_val;
          res.pulse_stop_time  = sto_val;
          res.pulse_length     = new_plen;
          upd.wr               = go;
        end
      end
      MODE_READ: begin
        if (sid_ok && cidx_ok) begin
          res.status        = ST_READ;
          res.machine       = item.machine;
          res.sid           = 12'(item.entry_sid);
          res.pulse_length  = rd.plen;
          res.counter_value = rd.cnt[item.counter_index];
        end
      end
      MODE_CLEAR: begin
        if (sid_ok) begin
          res.status = ST_CLEARED;
          res.sid    = 12'(item.entry_sid);
          upd.clr    = go;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/chopper_event_statistics_core.sv
`default_nettype none
// An accepted transaction moves from the input register to the result register.
// Throughput: one transaction per cycle unless the output stalls; each one works on
// the statistics of one SID in the single stage between the input and result registers.
// Reset (synchronous, active low) empties both registers, loads the register reset
// values and marks every statistics row as zero, usable in the next cycle.

module chopper_event_statistics_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // event_id[63:0], param_word[127:64], machine[128], entry_sid[132:129],
  // counter_index[136:133], zero fill above
  input  wire logic [cesc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode[1:0]
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_machine[0], out_sid[12:1], flag_bits[22:13], trigger_length[53:23],
  // pulse_start_time[84:54], pulse_stop_time[115:85], pulse_length[132:116],
  // counter_value[164:133], zero fill above
  output logic [cesc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // status[1:0]
  output logic [1:0]                             out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [15:0]                       cfg_wdata
);
  import cesc_pkg::*;

  cfg_t       cfg_r;
  item_t      item_r;
  logic       s1_valid_r;
  result_t    res_r;
  logic       out_valid_r;
  logic       s1_adv;
  logic       in_acc;
  logic       rd_machine;
  logic [SID_W-1:0] rd_idx;
  store_rd_t  rd;
  store_upd_t upd;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format_code  <= 4'd1;
      cfg_r.invalid_code <= 16'hffff;
      cfg_r.nodata_code  <= 16'hfffe;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT:  cfg_r.format_code  <= cfg_wdata[3:0];
        CFG_INVALID: cfg_r.invalid_code <= cfg_wdata;
        CFG_NODATA:  cfg_r.nodata_code  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.mode          <= in_tuser;
      item_r.event_id      <= in_tdata[63:0];
      item_r.param_word    <= in_tdata[127:64];
      item_r.machine       <= in_tdata[128];
      item_r.entry_sid     <= in_tdata[132:129];
      item_r.counter_index <= in_tdata[136:133];
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  cesc_calc u_calc (
    .item       (item_r),
    .cfg        (cfg_r),
    .go         (s1_adv),
    .rd_machine (rd_machine),
    .rd_idx     (rd_idx),
    .rd         (rd),
    .res        (res),
    .upd        (upd)
  );

  cesc_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_machine (rd_machine),
    .rd_idx     (rd_idx),
    .rd         (rd),
    .upd        (upd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {3'b000, res_r.counter_value, res_r.pulse_length,
                       res_r.pulse_stop_time, res_r.pulse_start_time,
                       res_r.trigger_length, res_r.flag_bits, res_r.sid,
                       res_r.machine};

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_DROPPED) |-> (out_tdata == '0))
    else $error("dropped transaction carries nonzero fields");

  a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_CLEARED) |->
      (!res_r.machine && res_r.counter_value == '0 && res_r.flag_bits == '0))
    else $error("clear transaction carries nonzero fields");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_APPLIED) |->
      !(res_r.flag_bits[8] && res_r.flag_bits[9]))
    else $error("wrong trigger and failed chop both set");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.wr || upd.clr) |-> (s1_adv && !(upd.wr && upd.clr)))
    else $error("store update without advancing transaction");
`endif

endmodule

`default_nettype wire

FILE: tb/chopper_event_statistics_core_tb.sv
`timescale 1ns / 100ps

module chopper_event_statistics_core_tb;
  import cesc_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 160;

  class chopper_stats_tracker;
    logic [CNT_W-1:0] counts [2][SID_COUNT][NCNT];
    logic [PLEN_W-1:0] last_length [2][SID_COUNT];
    logic [3:0] fmt;
    logic [15:0] inv_code;
    logic [15:0] nod_code;
    result_t pending_results[$];
    int failures;
    int checked;
    int by_status [4];

    function new();
      foreach (counts[m, s, c]) counts[m][s][c] = '0;
      foreach (last_length[m, s]) last_length[m][s] = '0;
      foreach (by_status[i]) by_status[i] = 0;
      fmt = 4'd1;
      inv_code = 16'hffff;
      nod_code = 16'hfffe;
      failures = 0;
      checked = 0;
    endfunction

    function void set_register(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        CFG_FORMAT:  fmt = data[3:0];
        CFG_INVALID: inv_code = data;
        CFG_NODATA:  nod_code = data;
        default: ;
      endcase
    endfunction

    function bit classify(input logic [15:0] raw, output logic [MEAS_W-1:0] shown);
      if (raw == inv_code) begin
        shown = MEAS_INVALID;
        return 1'b0;
      end
      if (raw == nod_code) begin
        shown = '0;
        return 1'b0;
      end
      shown = MEAS_W'(raw);
      return 1'b1;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Works out the result of one accepted input transaction and updates the statistics.
    function void apply_transaction(input item_t it);
      result_t r;
      logic [11:0] sid;
      logic [13:0] bpid;
      logic [5:0] attr;
      logic [15:0] start_raw, stop_raw;
      logic [MEAS_W-1:0] tval, saval, soval;
      logic [NCNT-1:0] hits;
      logic [SID_W-1:0] s;
      bit blk, ilk, crec, clate, nob, trg, sta, sto, wt, fc;
      r = '0;
      r.status = ST_DROPPED;
      case (mode_t'(it.mode))
        MODE_EVENT: begin
          sid = it.event_id[31:20];
          if (it.event_id[63:60] == fmt && sid < SID_COUNT) begin
            s = sid[SID_W-1:0];
            bpid = it.event_id[19:6];
            attr = it.event_id[5:0];
            blk = bpid[2];
            ilk = bpid[3];
            crec = bpid[4];
            clate = bpid[5];
            nob = attr[2];
            start_raw = it.param_word[47:32];
            stop_raw = it.param_word[31:16];
            trg = classify(it.param_word[63:48], tval);
            sta = classify(start_raw, saval);
            sto = classify(stop_raw, soval);
            if (sta && sto)
              last_length[it.machine][s] = {1'b0, stop_raw} - {1'b0, start_raw};
            wt = (nob | blk | ilk) & trg;
            fc = !(nob | blk | ilk) && !sto;
            hits = '0;
            hits[C_CYCLES] = 1'b1;
            hits[C_TRIGGER] = trg;
            hits[C_START] = sta;
            hits[C_STOP] = sto;
            hits[C_NOBEAM] = nob;
            hits[C_BLOCK] = blk;
            hits[C_INTERLOCK] = ilk;
            hits[C_FAILCHOP] = fc;
            hits[C_WRONGTRIG] = wt;
            hits[C_CCIREC] = crec;
            hits[C_CCILATE] = clate;
            for (int c = 0; c < NCNT; c++)
              if (hits[c]) counts[it.machine][s][c] = counts[it.machine][s][c] + 1'b1;
            r.status = ST_APPLIED;
            r.machine = it.machine;
            r.sid = sid;
            r.flag_bits = {fc, wt, clate, crec, ilk, blk, nob, sto, sta, trg};
            r.trigger_length = tval;
            r.pulse_start_time = saval;
            r.pulse_stop_time = soval;
            r.pulse_length = last_length[it.machine][s];
          end
        end
        MODE_READ: begin
          if (it.entry_sid < SID_COUNT && it.counter_index < NCNT) begin
            s = it.entry_sid[SID_W-1:0];
            r.status = ST_READ;
            r.machine = it.machine;
            r.sid = 12'(it.entry_sid);
            r.pulse_length = last_length[it.machine][s];
            r.counter_value = counts[it.machine][s][it.counter_index];
          end
        end
        MODE_CLEAR: begin
          if (it.entry_sid < SID_COUNT) begin
            s = it.entry_sid[SID_W-1:0];
            for (int m = 0; m < 2; m++) begin
              for (int c = 0; c < NCNT; c++) counts[m][s][c] = '0;
              last_length[m][s] = '0;
            end
            r.status = ST_CLEARED;
            r.sid = 12'(it.entry_sid);
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void field_check(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: result %0d %s expected %0h actual %0h", $time, checked, name,
                 want, got);
      end
    endfunction

    function void compare_result(input logic [1:0] st, input logic [OUT_TDATA_W-1:0] data);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result %0d expected none actual status %0h data %0h", $time,
                 checked, st, data);
        checked++;
        return;
      end
      want = pending_results.pop_front();
      by_status[want.status]++;
      field_check("status", 64'(want.status), 64'(st));
      field_check("out_machine", 64'(want.machine), 64'(data[0]));
      field_check("out_sid", 64'(want.sid), 64'(data[12:1]));
      field_check("flag_bits", 64'(want.flag_bits), 64'(data[22:13]));
      field_check("trigger_length", 64'(want.trigger_length), 64'(data[53:23]));
      field_check("pulse_start_time", 64'(want.pulse_start_time), 64'(data[84:54]));
      field_check("pulse_stop_time", 64'(want.pulse_stop_time), 64'(data[115:85]));
      field_check("pulse_length", 64'(want.pulse_length), 64'(data[132:116]));
      field_check("counter_value", 64'(want.counter_value), 64'(data[164:133]));
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  chopper_stats_tracker sb;
  int unsigned src_calm = 0;
  int unsigned sink_calm = 0;
  bit hold_request = 1'b0;
  int long_holds = 0;
  int settings_used = 0;
  int cycle_count = 0;

  chopper_event_statistics_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Gaps run in calm stretches with no idling, otherwise they are drawn at random.
  function automatic int draw_gap(input bit sink_side);
    int unsigned calm;
    calm = sink_side ? sink_calm : src_calm;
    if (calm > 0) begin
      calm--;
    end else if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
    end
    if (sink_side) sink_calm = calm;
    else src_calm = calm;
    return (calm > 0) ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [15:0] pick_measurement();
    case ($urandom_range(0, 9))
      0, 1: return sb.inv_code;
      2, 3: return sb.nod_code;
      4: return 16'h0000;
      5: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t event_item(input logic mach, input logic [11:0] sid,
                                       input logic [13:0] bpid, input logic [5:0] attr,
                                       input logic [15:0] trg, input logic [15:0] sta,
                                       input logic [15:0] sto);
    item_t it;
    it = '0;
    it.mode = MODE_EVENT;
    it.event_id = {sb.fmt, 28'($urandom), sid, bpid, attr};
    it.param_word = {trg, sta, sto, 16'($urandom)};
    it.machine = mach;
    it.entry_sid = 4'($urandom);
    it.counter_index = 4'($urandom);
    return it;
  endfunction

  function automatic item_t query_item(input logic mach, input logic [3:0] sid,
                                       input logic [3:0] idx);
    item_t it;
    it = '0;
    it.mode = MODE_READ;
    it.event_id = {$urandom, $urandom};
    it.param_word = {$urandom, $urandom};
    it.machine = mach;
    it.entry_sid = sid;
    it.counter_index = idx;
    return it;
  endfunction

  function automatic item_t clear_item(input logic [3:0] sid);
    item_t it;
    it = query_item(1'($urandom), sid, 4'($urandom));
    it.mode = MODE_CLEAR;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    logic [11:0] sid;
    pick = $urandom_range(0, 99);
    sid = ($urandom_range(0, 11) == 0) ? 12'($urandom_range(SID_COUNT, 4095))
                                       : 12'($urandom_range(0, SID_COUNT - 1));
    if (pick < 58) begin
      it = event_item(1'($urandom), sid, 14'($urandom), 6'($urandom), pick_measurement(),
                      pick_measurement(), pick_measurement());
      if ($urandom_range(0, 9) == 0) it.event_id[63:60] = 4'($urandom);
    end else if (pick < 90) begin
      it = query_item(1'($urandom), 4'($urandom),
                      ($urandom_range(0, 7) == 0) ? 4'($urandom_range(NCNT, 15))
                                                  : 4'($urandom_range(0, NCNT - 1)));
    end else if (pick < 93) begin
      it = clear_item(4'($urandom));
    end else if (pick < 96) begin
      it = query_item(1'($urandom), 4'($urandom), 4'($urandom));
      it.mode = MODE_UNUSED;
    end else begin
      it = query_item(1'($urandom), 4'($urandom), 4'($urandom));
      it.mode = MODE_EVENT;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = draw_gap(1'b0);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.mode;
    in_tdata <= {7'd0, it.counter_index, it.entry_sid, it.machine, it.param_word,
                 it.event_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_transaction(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic program_codes(input logic [3:0] fmt, input logic [15:0] inv,
                               input logic [15:0] nod);
    write_reg(CFG_FORMAT, {12'($urandom), fmt});
    write_reg(CFG_INVALID, inv);
    write_reg(CFG_NODATA, nod);
    settings_used++;
  endtask

  // Events whose measurements hit the current invalid and no-data codes exactly.
  task automatic code_items();
    send_item(event_item(1'b0, 12'd3, 14'd0, 6'd0, sb.inv_code, sb.nod_code, 16'd9));
    send_item(event_item(1'b1, 12'd3, 14'd0, 6'd0, sb.nod_code, 16'd4, sb.inv_code));
    send_item(event_item(1'b1, 12'd3, 14'd0, 6'd0, 16'd2, sb.inv_code, sb.nod_code));
  endtask

  task automatic directed_items();
    item_t it;
    send_item(event_item(1'b0, 12'd0, 14'd0, 6'd0, 16'd100, 16'd10, 16'd60));
    send_item(event_item(1'b0, 12'd0, 14'd0, 6'h04, 16'd5, 16'hffff, 16'hfffe));
    send_item(event_item(1'b0, 12'd0, 14'h0004, 6'd0, 16'hfffe, 16'd0, 16'hffff));
    send_item(event_item(1'b1, 12'd15, 14'h0038, 6'h3b, 16'hffff, 16'd7, 16'd3));
    send_item(event_item(1'b1, 12'd15, 14'h3fff, 6'h3f, 16'd0, 16'hfffd, 16'd0));
    send_item(event_item(1'b0, 12'd1, 14'd0, 6'd0, 16'hfffd, 16'd0, 16'hfffd));
    send_item(event_item(1'b0, 12'd1, 14'd0, 6'd0, 16'd0, 16'd0, 16'hfffe));
    it = event_item(1'b0, 12'd2, 14'd0, 6'd0, 16'd1, 16'd2, 16'd3);
    it.event_id[63:60] = sb.fmt + 4'd1;
    send_item(it);
    send_item(event_item(1'b1, 12'd16, 14'd0, 6'd0, 16'd1, 16'd2, 16'd3));
    send_item(event_item(1'b1, 12'hfff, 14'h3fff, 6'h3f, 16'd1, 16'd2, 16'd3));
    for (int c = 0; c < NCNT; c++) send_item(query_item(1'b0, 4'd0, 4'(c)));
    send_item(query_item(1'b1, 4'd15, C_CYCLES));
    send_item(query_item(1'b0, 4'd0, 4'hf));
    it = query_item(1'b1, 4'd15, C_TRIGGER);
    it.mode = MODE_UNUSED;
    send_item(it);
    send_item(clear_item(4'd0));
    send_item(query_item(1'b0, 4'd0, C_CYCLES));
    send_item(query_item(1'b1, 4'd0, C_CYCLES));
  endtask

  task automatic random_items(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      send_item(random_item());
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(1'b1);
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        long_holds++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.compare_result(out_tuser, out_tdata);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_codes(4'd1, 16'hffff, 16'hfffe);
    directed_items();
    random_items(220, 90);

    drain();
    program_codes(4'd0, 16'h0000, 16'h0001);
    write_reg(CFG_SPARE, 16'($urandom));
    code_items();
    random_items(110, -1);
    drain();
    random_items(110, 40);

    drain();
    program_codes(4'd15, 16'h1234, 16'h1234);
    code_items();
    send_item(event_item(1'b1, 12'd15, 14'h3fff, 6'h3f, 16'hffff, 16'hffff, 16'hffff));
    random_items(220, -1);

    drain();
    program_codes(4'($urandom), 16'($urandom), 16'($urandom));
    code_items();
    random_items(220, 120);

    drain();
    program_codes(4'd1, 16'hffff, 16'hfffe);
    code_items();
    random_items(220, -1);

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d transactions: %0d applied, %0d dropped, %0d reads, %0d clears.",
             sb.checked, sb.by_status[ST_APPLIED], sb.by_status[ST_DROPPED],
             sb.by_status[ST_READ], sb.by_status[ST_CLEARED]);
    $display("Used %0d register settings and %0d long output stalls; %0d mismatches.",
             settings_used, long_holds, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: chopper_event_statistics_core.f
rtl/core/cesc_pkg.sv
rtl/core/cesc_store.sv
rtl/core/cesc_calc.sv
rtl/core/chopper_event_statistics_core.sv
tb/chopper_event_statistics_core_tb.sv
